// ----- design/datetime_text_parser_defines.svh -----
// ----------------------------------------------------------------------------
// datetime_text_parser_defines.svh
// Assertion macros shared by the date-time text parser.
// ----------------------------------------------------------------------------
`ifndef DATETIME_TEXT_PARSER_DEFINES_SVH
`define DATETIME_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define DTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DTP_ASSERT_IMP(label, ante, cons, msg)
`define DTP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- design/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Types, character codes and helper functions of the date-time text parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Depth of both queues.
    localparam int unsigned Q_DEPTH = 2;

    typedef enum logic [2:0]
    {
        K_OTHER,
        K_DIGIT,
        K_DASH,
        K_T,
        K_COLON,
        K_DOT
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t  kind;
        logic [3:0]  digit;
        logic        last;
    } item_t;

    typedef struct packed
    {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [9:0]  second_frac;
        logic        valid_res;
    } result_t;

    function automatic logic [7:0] sat8(input logic [15:0] v);
        logic [7:0] r;
        begin
            r = (v > 16'd255) ? 8'd255 : v[7:0];
            return r;
        end
    endfunction

    function automatic int unsigned pow10(input int unsigned n);
        int unsigned r;
        begin
            case (n)
                0:       r = 1;
                1:       r = 10;
                2:       r = 100;
                3:       r = 1000;
                4:       r = 10000;
                5:       r = 100000;
                6:       r = 1000000;
                default: r = 1;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/dtp_fifo.sv -----
// ----------------------------------------------------------------------------
// dtp_fifo
// Small first-in first-out queue held in registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/dtp_front.sv -----
// ----------------------------------------------------------------------------
// dtp_front
// Accepts characters and sorts each into separator, digit, dot or other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtp_front
    import dtp_pkg::*;
(
    input  wire logic       push,
    input  wire logic [7:0] ch,
    input  wire logic       last,
    output logic            full,
    input  wire logic       q_full,
    output logic            q_wr,
    output item_t           q_item
);

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        q_item.last  = last;
        q_item.digit = ch[3:0];
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            q_item.kind = K_DIGIT;
        end
        else if (ch == CH_DASH)
        begin
            q_item.kind = K_DASH;
        end
        else if (ch == CH_T)
        begin
            q_item.kind = K_T;
        end
        else if (ch == CH_COLON)
        begin
            q_item.kind = K_COLON;
        end
        else if (ch == CH_DOT)
        begin
            q_item.kind = K_DOT;
        end
        else
        begin
            q_item.kind = K_OTHER;
        end
    end

endmodule

`default_nettype wire

// ----- design/dtp_back.sv -----
// ----------------------------------------------------------------------------
// dtp_back
// Field parser: tracks separators, accumulates digits and builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtp_back
    import dtp_pkg::*;
#(
    parameter int unsigned FRAC_DIGITS = 3
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_avail,
    input  item_t      item,
    output logic       take,
    input  wire logic  res_full,
    output logic       res_push,
    output result_t    res
);

    localparam int unsigned FRAC_W = $clog2(10 ** FRAC_DIGITS);
    localparam int unsigned CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int unsigned EXT_W  = (FRAC_W > 10) ? FRAC_W : 10;

    logic [1:0]        dash_reg, dash_next;
    logic              t_reg, t_next;
    logic [1:0]        colon_reg, colon_next;
    logic              started_reg, started_next;
    logic              run_reg, run_next;
    logic              in_frac_reg, in_frac_next;
    logic [15:0]       acc_reg, acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ok_reg, ok_next;
    logic [15:0]       year_reg, year_next;
    logic [7:0]        month_reg, month_next;
    logic [7:0]        day_reg, day_next;
    logic [7:0]        hour_reg, hour_next;
    logic [7:0]        minute_reg, minute_next;

    logic [19:0]       acc_mul;
    logic [FRAC_W-1:0] weight;
    logic [EXT_W-1:0]  frac_ext;
    logic              flush;

    assign take     = in_avail && !res_full;
    assign res_push = take && item.last;

    // Times ten plus digit, wide enough to see overflow before saturating.
    assign acc_mul = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 20'(item.digit);

    // A fraction digit is added at its final place value, so no padding is
    // needed when fewer digits arrive.
    assign weight = FRAC_W'(pow10(32'(FRAC_DIGITS - 1) - 32'(cnt_reg)));

    always_comb
    begin
        dash_next    = dash_reg;
        t_next       = t_reg;
        colon_next   = colon_reg;
        started_next = started_reg;
        run_next     = run_reg;
        in_frac_next = in_frac_reg;
        acc_next     = acc_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        res          = '0;
        flush        = 1'b0;

        if (take && ok_reg)
        begin
            case (item.kind)
                K_DASH:
                begin
                    if (t_reg || colon_reg != 2'd0 || !started_reg || dash_reg == 2'd2)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        if (dash_reg == 2'd0)
                        begin
                            year_next = acc_reg;
                        end
                        else
                        begin
                            month_next = sat8(acc_reg);
                        end
                        dash_next = dash_reg + 2'd1;
                        flush     = 1'b1;
                    end
                end
                K_T:
                begin
                    if (t_reg || dash_reg != 2'd2 || !started_reg)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        day_next = sat8(acc_reg);
                        t_next   = 1'b1;
                        flush    = 1'b1;
                    end
                end
                K_COLON:
                begin
                    if (!t_reg || !started_reg || colon_reg == 2'd2)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        if (colon_reg == 2'd0)
                        begin
                            hour_next = sat8(acc_reg);
                        end
                        else
                        begin
                            minute_next = sat8(acc_reg);
                        end
                        colon_next = colon_reg + 2'd1;
                        flush      = 1'b1;
                    end
                end
                default:
                begin
                    started_next = 1'b1;
                    if (run_reg)
                    begin
                        if (item.kind == K_DIGIT)
                        begin
                            acc_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
                        end
                        else
                        begin
                            run_next     = 1'b0;
                            in_frac_next = (item.kind == K_DOT);
                        end
                    end
                    else if (in_frac_reg)
                    begin
                        if (item.kind == K_DIGIT)
                        begin
                            if (cnt_reg < CNT_W'(FRAC_DIGITS))
                            begin
                                frac_next = frac_reg + FRAC_W'(item.digit) * weight;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            in_frac_next = 1'b0;
                        end
                    end
                end
            endcase
        end

        if (flush)
        begin
            started_next = 1'b0;
            run_next     = 1'b1;
            in_frac_next = 1'b0;
            acc_next     = '0;
            frac_next    = '0;
            cnt_next     = '0;
        end

        frac_ext = EXT_W'(frac_next);

        if (res_push)
        begin
            res.year      = year_next;
            res.month     = month_next;
            res.day       = day_next;
            res.hour      = hour_next;
            res.minute    = minute_next;
            res.valid_res = ok_next;
            if (ok_next && started_next)
            begin
                if (t_next)
                begin
                    res.second      = sat8(acc_next);
                    res.second_frac = (frac_ext > EXT_W'(1023)) ? 10'd1023 : frac_ext[9:0];
                end
                else
                begin
                    res.day = sat8(acc_next);
                end
            end

            // Back to the start-of-string state for the next text.
            dash_next    = '0;
            t_next       = 1'b0;
            colon_next   = '0;
            started_next = 1'b0;
            run_next     = 1'b1;
            in_frac_next = 1'b0;
            acc_next     = '0;
            frac_next    = '0;
            cnt_next     = '0;
            ok_next      = 1'b1;
            year_next    = '0;
            month_next   = '0;
            day_next     = '0;
            hour_next    = '0;
            minute_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_reg    <= '0;
            t_reg       <= 1'b0;
            colon_reg   <= '0;
            started_reg <= 1'b0;
            run_reg     <= 1'b1;
            in_frac_reg <= 1'b0;
            acc_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            ok_reg      <= 1'b1;
            year_reg    <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
        end
        else
        begin
            dash_reg    <= dash_next;
            t_reg       <= t_next;
            colon_reg   <= colon_next;
            started_reg <= started_next;
            run_reg     <= run_next;
            in_frac_reg <= in_frac_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            cnt_reg     <= cnt_next;
            ok_reg      <= ok_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/datetime_text_parser.sv -----
// ----------------------------------------------------------------------------
// datetime_text_parser
// Character-serial parser for year-month-dayThour:minute:second text.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the character queue has room and
// one result beat is produced for the character marked last. The classifier
// feeds a two-entry character queue, the field parser handles one character
// per cycle from it while the result queue has room, and results wait in a
// two-entry result queue, so a stalled consumer only stops input once both
// queues have filled. A result beat is written into the result queue when
// the parser takes its last character and can then be popped; throughput is
// one character per cycle, set by the combinational times-ten accumulate.
`timescale 1ns / 1ps
`default_nettype none
`include "datetime_text_parser_defines.svh"

module datetime_text_parser
    import dtp_pkg::*;
#(
    parameter int unsigned FRAC_DIGITS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      year,
    output logic [7:0]       month,
    output logic [7:0]       day,
    output logic [7:0]       hour,
    output logic [7:0]       minute,
    output logic [7:0]       second,
    output logic [9:0]       second_frac,
    output logic             valid_res
);

    localparam int unsigned ITEM_W = $bits(item_t);
    localparam int unsigned RES_W  = $bits(result_t);

    item_t   wr_item, rd_item;
    logic    char_wr, char_full, char_empty, char_take;
    logic    res_push, res_full;
    result_t res_in, res_out;

    dtp_front u_front (
        .push   (push),
        .ch     (ch),
        .last   (last),
        .full   (full),
        .q_full (char_full),
        .q_wr   (char_wr),
        .q_item (wr_item)
    );

    dtp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_char_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (char_wr),
        .wr_data (wr_item),
        .full    (char_full),
        .rd_en   (char_take),
        .rd_data (rd_item),
        .empty   (char_empty)
    );

    dtp_back #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_avail (!char_empty),
        .item     (rd_item),
        .take     (char_take),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    dtp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign year        = res_out.year;
    assign month       = res_out.month;
    assign day         = res_out.day;
    assign hour        = res_out.hour;
    assign minute      = res_out.minute;
    assign second      = res_out.second;
    assign second_frac = res_out.second_frac;
    assign valid_res   = res_out.valid_res;

    // An invalid text never carries a second or a fraction.
    `DTP_ASSERT_IMP(a_invalid_no_second, !empty && !valid_res, second == 8'd0 && second_frac == 10'd0, "invalid result carries a second")
    // The parser only consumes characters that are present.
    `DTP_ASSERT_IMP(a_take_needs_char, char_take, !char_empty, "parser took from an empty queue")
    // Finishing a string always leaves a result beat waiting.
    `DTP_ASSERT_NEXT(a_last_gives_result, res_push, !empty, "result beat lost after last character")

endmodule

`default_nettype wire

// ----- test/datetime_text_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_text_parser_tb
// Feeds date-time strings one character per beat into the parser, predicts
// the parsed fields of every string in the testbench and compares each result
// beat with the prediction, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module datetime_text_parser_tb;
    import dtp_pkg::*;

    localparam int FRAC_DIGITS    = 3;
    localparam int ITEMS          = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 40;

    typedef struct
    {
        logic [7:0] code;
        logic       fin;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  ch = 8'h00;
    logic        last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [9:0]  second_frac;
    logic        valid_res;

    char_beat_t  char_queue[$];
    result_t     want_dates[$];
    logic [7:0]  txt[$];

    int n_accepted = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int calm_from = 0;
    int send_gap = 0;
    int take_gap = 0;

    // Parser state as the predictor sees it.
    int unsigned dash_cnt;
    int unsigned colon_cnt;
    logic        after_t;
    logic        fld_started;
    logic        in_int;
    logic        in_frac;
    logic        parse_ok;
    int unsigned int_acc;
    int unsigned frac_acc;
    int unsigned frac_cnt;
    logic [15:0] got_year;
    logic [7:0]  got_month;
    logic [7:0]  got_day;
    logic [7:0]  got_hour;
    logic [7:0]  got_minute;

    datetime_text_parser #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .last        (last),
        .empty       (empty),
        .pop         (pop),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .second_frac (second_frac),
        .valid_res   (valid_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] sat_byte(input int unsigned v);
        begin
            return (v > 255) ? 8'd255 : v[7:0];
        end
    endfunction

    task automatic open_field();
        begin
            fld_started = 1'b0;
            in_int      = 1'b1;
            in_frac     = 1'b0;
            int_acc     = 0;
            frac_acc    = 0;
            frac_cnt    = 0;
        end
    endtask

    task automatic clear_parser();
        begin
            dash_cnt   = 0;
            colon_cnt  = 0;
            after_t    = 1'b0;
            parse_ok   = 1'b1;
            got_year   = '0;
            got_month  = '0;
            got_day    = '0;
            got_hour   = '0;
            got_minute = '0;
            open_field();
        end
    endtask

    // Applies one accepted character; on the final one of a string the
    // expected date is queued and the parser returns to its idle state.
    task automatic advance_parser(input logic [7:0] c, input logic fin);
        result_t     r;
        int unsigned f;
        logic        is_digit;
        begin
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (parse_ok)
            begin
                if (c == CH_DASH)
                begin
                    if (after_t || colon_cnt != 0 || !fld_started || dash_cnt >= 2)
                        parse_ok = 1'b0;
                    else
                    begin
                        if (dash_cnt == 0)
                            got_year = int_acc[15:0];
                        else
                            got_month = sat_byte(int_acc);
                        dash_cnt++;
                        open_field();
                    end
                end
                else if (c == CH_T)
                begin
                    if (after_t || dash_cnt != 2 || !fld_started)
                        parse_ok = 1'b0;
                    else
                    begin
                        got_day = sat_byte(int_acc);
                        after_t = 1'b1;
                        open_field();
                    end
                end
                else if (c == CH_COLON)
                begin
                    if (!after_t || !fld_started || colon_cnt >= 2)
                        parse_ok = 1'b0;
                    else
                    begin
                        if (colon_cnt == 0)
                            got_hour = sat_byte(int_acc);
                        else
                            got_minute = sat_byte(int_acc);
                        colon_cnt++;
                        open_field();
                    end
                end
                else
                begin
                    fld_started = 1'b1;
                    if (in_int)
                    begin
                        if (is_digit)
                        begin
                            int_acc = int_acc * 10 + (c - CH_ZERO);
                            if (int_acc > 65535)
                                int_acc = 65535;
                        end
                        else
                        begin
                            in_int  = 1'b0;
                            in_frac = (c == CH_DOT);
                        end
                    end
                    else if (in_frac)
                    begin
                        if (!is_digit)
                            in_frac = 1'b0;
                        else if (frac_cnt < FRAC_DIGITS)
                        begin
                            frac_acc = frac_acc * 10 + (c - CH_ZERO);
                            frac_cnt++;
                        end
                    end
                end
            end

            if (fin)
            begin
                r = '0;
                if (parse_ok && fld_started)
                begin
                    if (after_t)
                    begin
                        r.second = sat_byte(int_acc);
                        f = frac_acc;
                        for (int unsigned n = frac_cnt; n < FRAC_DIGITS; n++)
                            f = f * 10;
                        r.second_frac = (f > 1023) ? 10'd1023 : f[9:0];
                    end
                    else
                        got_day = sat_byte(int_acc);
                end
                r.year      = got_year;
                r.month     = got_month;
                r.day       = got_day;
                r.hour      = got_hour;
                r.minute    = got_minute;
                r.valid_res = parse_ok;
                want_dates.push_back(r);
                clear_parser();
            end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        begin
            if (n_errors < MAX_REPORTS)
                $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
            n_errors++;
        end
    endtask

    // Moves the text being built into the queue of characters to send.
    task automatic commit_text();
        begin
            if (txt.size() == 0)
                txt.push_back(CH_ZERO);
            foreach (txt[i])
                char_queue.push_back('{code: txt[i], fin: (i == txt.size() - 1)});
            txt.delete();
        end
    endtask

    task automatic add_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                txt.push_back(s[i]);
            commit_text();
        end
    endtask

    function automatic logic [7:0] sep_char();
        begin
            case ($urandom_range(0, 2))
                0:       return CH_DASH;
                1:       return CH_T;
                default: return CH_COLON;
            endcase
        end
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_DASH || c == CH_T || c == CH_COLON);
            return c;
        end
    endfunction

    task automatic put_digits(input int n);
        begin
            repeat (n)
                txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic put_field(input logic is_sec);
        int n;
        begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = $urandom_range(4, 7);
                default: n = $urandom_range(1, 3);
            endcase
            put_digits(n);
            if ($urandom_range(0, 5) == 0)
                txt.push_back(junk_char());
            if (is_sec && $urandom_range(0, 1) == 1)
            begin
                txt.push_back(CH_DOT);
                put_digits($urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0)
                    txt.push_back(junk_char());
            end
        end
    endtask

    // Mostly well-formed date-times with random content, some cut short or
    // damaged, and a share of pure noise.
    task automatic make_random_date();
        int parts;
        int k;
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 3) == 0)
                        txt.push_back(sep_char());
                    else
                        txt.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                parts = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 6;
                for (k = 0; k < parts; k++)
                begin
                    put_field(k == 5);
                    if (k < parts - 1 || $urandom_range(0, 7) == 0)
                        txt.push_back((k < 2) ? CH_DASH : (k == 2) ? CH_T : CH_COLON);
                end
                if ($urandom_range(0, 4) == 0 && txt.size() > 0)
                begin
                    k = $urandom_range(0, txt.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       txt[k] = sep_char();
                        1:       txt.delete(k);
                        default: txt.insert(k, sep_char());
                    endcase
                end
            end
            commit_text();
        end
    endtask

    // Character side: idles in random bursts until the closing part of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (char_queue.size() == 0)
                push <= 1'b0;
            else if (n_accepted < calm_from && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 13);
                push <= 1'b0;
            end
            else
            begin
                push <= 1'b1;
                ch   <= char_queue[0].code;
                last <= char_queue[0].fin;
            end
        end
    end

    // Result side: stalls in random bursts until the closing part of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else if (n_accepted < calm_from && $urandom_range(0, 7) == 0)
            begin
                take_gap = $urandom_range(0, 13);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t w;
        logic    moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                advance_parser(ch, last);
                void'(char_queue.pop_front());
                n_accepted++;
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (want_dates.size() == 0)
                    report("result beat with nothing expected, valid_res", valid_res, 0);
                else
                begin
                    w = want_dates.pop_front();
                    if (year !== w.year)
                        report("year", year, w.year);
                    if (month !== w.month)
                        report("month", month, w.month);
                    if (day !== w.day)
                        report("day", day, w.day);
                    if (hour !== w.hour)
                        report("hour", hour, w.hour);
                    if (minute !== w.minute)
                        report("minute", minute, w.minute);
                    if (second !== w.second)
                        report("second", second, w.second);
                    if (second_frac !== w.second_frac)
                        report("second_frac", second_frac, w.second_frac);
                    if (valid_res !== w.valid_res)
                        report("valid_res", valid_res, w.valid_res);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_parser();

        // Empty leading field, a full date-time with a short fraction, a lone
        // day, the extreme byte values, a trailing separator, a T with too
        // few dashes and a colon before any T.
        add_text("-");
        add_text("1-2-3T4:5:6.7");
        add_text("7");
        txt = {8'hFF};
        commit_text();
        txt = {8'h00};
        commit_text();
        add_text("1-");
        add_text("1-2T");
        add_text("1:");

        while (char_queue.size() < ITEMS)
            make_random_date();
        calm_from = char_queue.size() * 9 / 10;

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (char_queue.size() == 0 && want_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
